### hdl/knt_pkg.sv
`default_nettype none
package knt_pkg;

  // field and register widths
  localparam int RANK_W   = 10;
  localparam int GS_W     = 11;
  localparam int RADIX_W  = 5;
  localparam int KIND_W   = 2;
  localparam int TDATA_W  = 16;
  localparam int APB_W    = 32;
  localparam int ADDR_W   = 4;

  localparam int DEF_MAX_RANKS = 1024;
  localparam int DEF_MAX_RADIX = 16;

  // register reset values
  localparam logic [GS_W-1:0]    GROUP_SIZE_RST = GS_W'(1);
  localparam logic [RANK_W-1:0]  ROOT_RANK_RST  = '0;
  localparam logic [RADIX_W-1:0] TREE_RADIX_RST = RADIX_W'(2);

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_GROUP_SIZE = 2'd0;
  localparam logic [1:0] REG_ROOT_RANK  = 2'd1;
  localparam logic [1:0] REG_TREE_RADIX = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PARENT    = 2'd0,
    KIND_NO_PARENT = 2'd1,
    KIND_CHILD     = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_t;

endpackage
`default_nettype wire

### hdl/knomial_tree_neighbours_unit.sv
// the time per query grows with the tree levels tested (at most log2 of MAX_RANKS), the child
// levels and the child candidates tested; the shared radix divider works one quotient bit per
// cycle; a rank out of range goes straight to its final entry without the divider
// throughput: one query at a time, the next is taken once the last item is in the output reg
// reset (synchronous, active high) empties the block and sets group size 1, root 0, radix 2
`default_nettype none
module knomial_tree_neighbours_unit #(
  parameter int MAX_RANKS = knt_pkg::DEF_MAX_RANKS,
  parameter int MAX_RADIX = knt_pkg::DEF_MAX_RADIX
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [knt_pkg::TDATA_W-1:0]  s_tdata,   // [9:0] query_rank
  // output stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [knt_pkg::TDATA_W-1:0]       m_tdata,   // [9:0] peer_rank
  output logic [knt_pkg::KIND_W-1:0]        m_tuser,   // [1:0] entry_kind
  output logic                              m_tlast,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [knt_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [knt_pkg::APB_W-1:0]    pwdata,
  output logic [knt_pkg::APB_W-1:0]         prdata,
  output logic                              pready
);

  localparam int NW       = $clog2(MAX_RANKS + 1);
  localparam int KW       = $clog2(MAX_RADIX + 1);
  localparam int SW       = NW + KW;
  localparam int DW       = (NW > knt_pkg::RANK_W) ? NW : knt_pkg::RANK_W;
  localparam int DVW      = (NW > KW) ? NW : KW;
  localparam int LVLS_RAW = $clog2(MAX_RANKS);
  localparam int LVLS     = (LVLS_RAW < 2) ? 2 : LVLS_RAW;
  localparam int IDX_W    = $clog2(LVLS);
  localparam int CNT_W    = $clog2(LVLS + 1);
  localparam int DCNT_W   = $clog2(DW + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_VR,
    ST_CLIMB_TEST,
    ST_CLIMB_CHECK,
    ST_PARENT_EMIT,
    ST_CHILD_LVL,
    ST_CHILD_EMIT,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [knt_pkg::GS_W-1:0]    group_size;
  logic [knt_pkg::RANK_W-1:0]  root_rank;
  logic [knt_pkg::RADIX_W-1:0] tree_radix;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      knt_pkg::REG_GROUP_SIZE: prdata = knt_pkg::APB_W'(group_size);
      knt_pkg::REG_ROOT_RANK:  prdata = knt_pkg::APB_W'(root_rank);
      knt_pkg::REG_TREE_RADIX: prdata = knt_pkg::APB_W'(tree_radix);
      default:                 prdata = '0;
    endcase
  end

  // effective group size and radix
  logic [NW-1:0] n_cfg;
  logic [KW-1:0] k_cfg;

  always_comb begin
    if (group_size == '0) begin
      n_cfg = NW'(1);
    end else if (32'(group_size) > MAX_RANKS) begin
      n_cfg = NW'(MAX_RANKS);
    end else begin
      n_cfg = NW'(group_size);
    end
    if (32'(tree_radix) < 2) begin
      k_cfg = KW'(2);
    end else if (32'(tree_radix) > MAX_RADIX) begin
      k_cfg = KW'(MAX_RADIX);
    end else begin
      k_cfg = KW'(tree_radix);
    end
  end

  // working registers
  logic [NW-1:0]     n_r;
  logic [KW-1:0]     k_r;
  logic [knt_pkg::RANK_W-1:0] q_r;
  logic [NW-1:0]     root_r;
  logic [NW-1:0]     vr;
  logic [NW-1:0]     qv;
  logic [SW-1:0]     mask;
  logic [NW-1:0]     prod;
  logic [CNT_W-1:0]  lvl;
  logic [NW-1:0]     m_step;
  logic [NW:0]       c;
  logic [KW-1:0]     d;
  logic [NW-1:0]     pow [LVLS];

  // shared restoring divider
  logic [DW-1:0]     div_quo;
  logic [DVW-1:0]    div_rem;
  logic [DVW-1:0]    div_den;
  logic [DCNT_W-1:0] div_cnt;
  logic              div_for_root;
  logic [DVW:0]      div_trial;
  logic              div_bit;
  logic [DVW-1:0]    div_rem_next;

  always_comb begin
    div_trial = {div_rem, div_quo[DW-1]};
    div_bit   = (div_trial >= {1'b0, div_den});
    if (div_bit) begin
      div_rem_next = DVW'(div_trial - {1'b0, div_den});
    end else begin
      div_rem_next = DVW'(div_trial);
    end
  end

  // digit-by-power multiplier
  logic [KW-1:0] rem_k;
  logic [KW-1:0] mul_b;
  logic [SW-1:0] mul_out;

  assign rem_k   = KW'(div_rem);
  assign mul_b   = (rem_k != '0) ? rem_k : k_r;
  assign mul_out = SW'(mask[NW-1:0]) * SW'(mul_b);

  // datapath helpers
  logic [NW:0]    vr_sum;
  logic [NW-1:0]  vr_calc;
  logic [NW-1:0]  par_base;
  logic [NW:0]    par_sum;
  logic [NW-1:0]  par_peer;
  logic [NW:0]    ch_sum;
  logic [NW-1:0]  ch_peer;
  logic           c_in_group;
  logic [IDX_W-1:0] lvl_idx;
  logic [CNT_W-1:0] lvl_dec;

  always_comb begin
    vr_sum = (NW+1)'(q_r) + (NW+1)'(n_r) - (NW+1)'(root_r);
    if (vr_sum >= (NW+1)'(n_r)) begin
      vr_calc = NW'(vr_sum - (NW+1)'(n_r));
    end else begin
      vr_calc = NW'(vr_sum);
    end
    par_base = vr - prod;
    par_sum  = (NW+1)'(par_base) + (NW+1)'(root_r);
    if (par_sum >= (NW+1)'(n_r)) begin
      par_peer = NW'(par_sum - (NW+1)'(n_r));
    end else begin
      par_peer = NW'(par_sum);
    end
    c_in_group = (c < (NW+1)'(n_r));
    ch_sum     = c + (NW+1)'(root_r);
    if (ch_sum >= (NW+1)'(n_r)) begin
      ch_peer = NW'(ch_sum - (NW+1)'(n_r));
    end else begin
      ch_peer = NW'(ch_sum);
    end
    lvl_dec = lvl - CNT_W'(1);
    lvl_idx = lvl_dec[IDX_W-1:0];
  end

  // one item waits in pend so the final one can be flagged
  logic                       pend_valid;
  knt_pkg::kind_t             pend_kind;
  logic [knt_pkg::RANK_W-1:0] pend_peer;
  logic                       out_free;
  logic                       can_emit;
  logic                       out_load;
  logic [knt_pkg::RANK_W-1:0] query;

  assign out_free = !m_tvalid || m_tready;
  assign can_emit = !pend_valid || out_free;
  assign s_tready = (state == ST_IDLE);
  assign query    = s_tdata[knt_pkg::RANK_W-1:0];
  // the output register takes the waiting item this cycle
  assign out_load = ((state == ST_CHILD_EMIT) && c_in_group && pend_valid && out_free) ||
                    ((state == ST_FINISH) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      group_size <= knt_pkg::GROUP_SIZE_RST;
      root_rank  <= knt_pkg::ROOT_RANK_RST;
      tree_radix <= knt_pkg::TREE_RADIX_RST;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      lvl        <= '0;
      div_cnt    <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          knt_pkg::REG_GROUP_SIZE: group_size <= pwdata[knt_pkg::GS_W-1:0];
          knt_pkg::REG_ROOT_RANK:  root_rank  <= pwdata[knt_pkg::RANK_W-1:0];
          knt_pkg::REG_TREE_RADIX: tree_radix <= pwdata[knt_pkg::RADIX_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            n_r <= n_cfg;
            k_r <= k_cfg;
            q_r <= query;
            if (DW'(query) >= DW'(n_cfg)) begin
              pend_valid <= 1'b1;
              pend_kind  <= knt_pkg::KIND_ERROR;
              pend_peer  <= '0;
              state      <= ST_FINISH;
            end else begin
              div_quo      <= DW'(root_rank);
              div_rem      <= '0;
              div_den      <= DVW'(n_cfg);
              div_cnt      <= DCNT_W'(DW);
              div_for_root <= 1'b1;
              state        <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          div_quo <= {div_quo[DW-2:0], div_bit};
          div_rem <= div_rem_next;
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == DCNT_W'(1)) begin
            state <= div_for_root ? ST_VR : ST_CLIMB_CHECK;
          end
        end

        ST_VR: begin
          root_r <= NW'(div_rem);
          if (!div_for_root) begin
            vr    <= vr_calc;
            qv    <= vr_calc;
            mask  <= SW'(1);
            lvl   <= '0;
            state <= ST_CLIMB_TEST;
          end
          // root is latched first, the rotation uses it on the next cycle
          div_for_root <= 1'b0;
        end

        ST_CLIMB_TEST: begin
          if (mask < SW'(n_r)) begin
            div_quo      <= DW'(qv);
            div_rem      <= '0;
            div_den      <= DVW'(k_r);
            div_cnt      <= DCNT_W'(DW);
            div_for_root <= 1'b0;
            state        <= ST_DIV;
          end else begin
            pend_valid <= 1'b1;
            pend_kind  <= knt_pkg::KIND_NO_PARENT;
            pend_peer  <= '0;
            state      <= ST_CHILD_LVL;
          end
        end

        ST_CLIMB_CHECK: begin
          if (rem_k != '0) begin
            // lowest nonzero digit found, parent clears it
            prod  <= NW'(mul_out);
            state <= ST_PARENT_EMIT;
          end else begin
            pow[lvl[IDX_W-1:0]] <= mask[NW-1:0];
            lvl   <= lvl + CNT_W'(1);
            qv    <= NW'(div_quo);
            mask  <= mul_out;
            state <= ST_CLIMB_TEST;
          end
        end

        ST_PARENT_EMIT: begin
          pend_valid <= 1'b1;
          pend_kind  <= knt_pkg::KIND_PARENT;
          pend_peer  <= knt_pkg::RANK_W'(par_peer);
          state      <= ST_CHILD_LVL;
        end

        ST_CHILD_LVL: begin
          if (lvl == '0) begin
            state <= ST_FINISH;
          end else begin
            m_step <= pow[lvl_idx];
            c      <= (NW+1)'(vr) + (NW+1)'(pow[lvl_idx]);
            d      <= KW'(1);
            lvl    <= lvl_dec;
            state  <= ST_CHILD_EMIT;
          end
        end

        ST_CHILD_EMIT: begin
          if (!c_in_group) begin
            // larger digits only go further past the group end
            state <= ST_CHILD_LVL;
          end else if (can_emit) begin
            if (pend_valid) begin
              m_tdata  <= knt_pkg::TDATA_W'(pend_peer);
              m_tuser  <= pend_kind;
              m_tlast  <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_kind  <= knt_pkg::KIND_CHILD;
            pend_peer  <= knt_pkg::RANK_W'(ch_peer);
            c          <= c + (NW+1)'(m_step);
            d          <= d + KW'(1);
            if (d == k_r - KW'(1)) begin
              state <= ST_CHILD_LVL;
            end
          end
        end

        ST_FINISH: begin
          if (out_free) begin
            m_tdata    <= knt_pkg::TDATA_W'(pend_peer);
            m_tuser    <= pend_kind;
            m_tlast    <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### test/knomial_tree_neighbours_unit_tb.sv
`default_nettype none

typedef struct packed {
  knt_pkg::kind_t  kind;
  logic [9:0]      peer;
  logic            last;
} nbr_t;

// keeps its own copy of the registers and the neighbour lists still owed by the block
class neighbour_board;
  logic [10:0] gsize;
  logic [9:0]  root;
  logic [4:0]  radix;
  nbr_t        pending[$];
  nbr_t        fresh[$];
  int          errors;
  int          queries;
  int          entries;
  int          longest;

  function new();
    gsize   = knt_pkg::GROUP_SIZE_RST;
    root    = knt_pkg::ROOT_RANK_RST;
    radix   = knt_pkg::TREE_RADIX_RST;
    errors  = 0;
    queries = 0;
    entries = 0;
    longest = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      knt_pkg::REG_GROUP_SIZE: gsize = val[10:0];
      knt_pkg::REG_ROOT_RANK:  root  = val[9:0];
      knt_pkg::REG_TREE_RADIX: radix = val[4:0];
      default: ;
    endcase
  endfunction

  function void stage(knt_pkg::kind_t kind, int unsigned peer);
    nbr_t e;
    e.kind = kind;
    e.peer = 10'(peer);
    e.last = 1'b0;
    fresh.insert(fresh.size(), e);
  endfunction

  // builds the neighbour list of one accepted query
  function void note_query(logic [9:0] q);
    int unsigned n, k, top, vr, mask, span, c;
    bit found;
    n = gsize;
    k = radix;
    if (n == 0) n = 1;
    if (n > knt_pkg::DEF_MAX_RANKS) n = knt_pkg::DEF_MAX_RANKS;
    if (k < 2) k = 2;
    if (k > knt_pkg::DEF_MAX_RADIX) k = knt_pkg::DEF_MAX_RADIX;
    queries++;
    if (q >= n) begin
      stage(knt_pkg::KIND_ERROR, 0);
    end else begin
      top = root % n;
      vr = (q + n - top) % n;
      // climb until the lowest nonzero digit of the virtual rank shows
      mask = 1;
      found = 1'b0;
      while (mask < n && !found) begin
        span = mask * k;
        if (vr % span != 0) begin
          stage(knt_pkg::KIND_PARENT, ((vr / span) * span + top) % n);
          found = 1'b1;
        end else begin
          mask = span;
        end
      end
      if (!found) stage(knt_pkg::KIND_NO_PARENT, 0);
      mask = mask / k;
      while (mask > 0) begin
        for (int unsigned d = 1; d < k; d++) begin
          c = vr + mask * d;
          if (c < n) stage(knt_pkg::KIND_CHILD, (c + top) % n);
        end
        mask = mask / k;
      end
    end
    fresh[fresh.size()-1].last = 1'b1;
    if (fresh.size() > longest) longest = fresh.size();
    foreach (fresh[i]) pending.insert(pending.size(), fresh[i]);
    fresh.delete();
  endfunction

  function void check_entry(knt_pkg::kind_t kind, logic [9:0] peer, logic last);
    nbr_t want;
    entries++;
    if (pending.size() == 0) begin
      $error("unexpected item: entry_kind %0d peer_rank %0d last_entry %0b", kind, peer, last);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (kind !== want.kind) begin
      $error("entry_kind: expected %0d, got %0d", want.kind, kind);
      errors++;
    end
    if (peer !== want.peer) begin
      $error("peer_rank: expected %0d, got %0d", want.peer, peer);
      errors++;
    end
    if (last !== want.last) begin
      $error("last_entry: expected %0b, got %0b", want.last, last);
      errors++;
    end
  endfunction
endclass

module knomial_tree_neighbours_unit_tb;

  localparam int LIMIT         = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_QUERIES = 20;
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [knt_pkg::TDATA_W-1:0]  s_tdata;   // [9:0] query_rank
  logic                         m_tvalid;
  logic                         m_tready;
  logic [knt_pkg::TDATA_W-1:0]  m_tdata;   // [9:0] peer_rank
  logic [knt_pkg::KIND_W-1:0]   m_tuser;   // [1:0] entry_kind
  logic                         m_tlast;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [knt_pkg::ADDR_W-1:0]   paddr;
  logic [knt_pkg::APB_W-1:0]    pwdata;
  logic [knt_pkg::APB_W-1:0]    prdata;
  logic                         pready;

  neighbour_board board = new();
  int  burst_left;
  int  eff_size;
  int  settings_used;
  int  cycles;
  bit  hold_req;

  knomial_tree_neighbours_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: its own stall pattern, plus one long hold-off on request
  initial begin
    int hold_left;
    int rcyc;
    hold_left = 0;
    rcyc = 0;
    forever begin
      @(negedge clk);
      rcyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case ((rcyc / 128) % 4)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ((rcyc % 8) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_entry(knt_pkg::kind_t'(m_tuser), m_tdata[knt_pkg::RANK_W-1:0], m_tlast);
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // sender works in bursts; valid stays up between items of one burst
  task automatic send_query(int q);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6)) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 8);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= knt_pkg::TDATA_W'(q[knt_pkg::RANK_W-1:0]);
    do @(posedge clk); while (!s_tready);
    board.note_query(q[knt_pkg::RANK_W-1:0]);
    burst_left--;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_config();
    logic [31:0] junk;
    int gs;
    case ($urandom_range(0, 7))
      0: gs = 1024;
      1: gs = $urandom_range(1, 16);
      2: gs = $urandom_range(1025, 2047);
      3: gs = $urandom_range(0, 1);
      default: gs = $urandom_range(2, 1024);
    endcase
    eff_size = (gs == 0) ? 1 : ((gs > 1024) ? 1024 : gs);
    junk = $urandom();
    apb_write(knt_pkg::REG_GROUP_SIZE, {junk[31:11], 11'(gs)});
    junk = $urandom();
    if ($urandom_range(0, 3) == 0)
      apb_write(knt_pkg::REG_ROOT_RANK, {junk[31:10], 10'($urandom_range(0, 1023))});
    else
      apb_write(knt_pkg::REG_ROOT_RANK, {junk[31:10], 10'($urandom_range(0, eff_size - 1))});
    junk = $urandom();
    case ($urandom_range(0, 5))
      0: apb_write(knt_pkg::REG_TREE_RADIX, {junk[31:5], 5'($urandom_range(0, 1))});
      1: apb_write(knt_pkg::REG_TREE_RADIX, {junk[31:5], 5'($urandom_range(17, 31))});
      2: apb_write(knt_pkg::REG_TREE_RADIX, {junk[31:5], 5'd16});
      3: apb_write(knt_pkg::REG_TREE_RADIX, {junk[31:5], 5'd2});
      default: apb_write(knt_pkg::REG_TREE_RADIX, {junk[31:5], 5'($urandom_range(2, 16))});
    endcase
    if ($urandom_range(0, 3) == 0) apb_write(REG_SPARE, $urandom());
  endtask

  initial begin
    int q;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    hold_req = 1'b0;
    burst_left = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // reset settings: one-rank group, anything else out of range
    send_query(0);
    send_query(1);
    send_query(1023);
    settle();

    // zero group size and radix below two; the spare register must not matter
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    apb_write(knt_pkg::REG_GROUP_SIZE, 32'd0);
    apb_write(knt_pkg::REG_TREE_RADIX, 32'd0);
    send_query(0);
    send_query(5);
    settle();

    // full group, widest radix, root at the top rank
    apb_write(knt_pkg::REG_GROUP_SIZE, 32'd1024);
    apb_write(knt_pkg::REG_ROOT_RANK, 32'd1023);
    apb_write(knt_pkg::REG_TREE_RADIX, 32'd16);
    send_query(1023);
    send_query(0);
    send_query(1);
    send_query(512);
    send_query(1022);
    settle();

    // oversized group and radix saturate
    apb_write(knt_pkg::REG_GROUP_SIZE, 32'h7FF);
    apb_write(knt_pkg::REG_ROOT_RANK, 32'd0);
    apb_write(knt_pkg::REG_TREE_RADIX, 32'd31);
    send_query(0);
    send_query(1023);
    send_query(768);
    settle();

    // root beyond the group wraps around
    apb_write(knt_pkg::REG_GROUP_SIZE, 32'd37);
    apb_write(knt_pkg::REG_ROOT_RANK, 32'd100);
    apb_write(knt_pkg::REG_TREE_RADIX, 32'd3);
    send_query(26);
    send_query(0);
    send_query(36);
    send_query(37);
    send_query(1023);
    settle();

    apb_write(knt_pkg::REG_GROUP_SIZE, 32'd1000);
    apb_write(knt_pkg::REG_ROOT_RANK, 32'd999);
    apb_write(knt_pkg::REG_TREE_RADIX, 32'd2);
    send_query(999);
    send_query(998);
    send_query(500);
    send_query(1000);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      // one long output stall while queries keep coming
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_QUERIES; i++) begin
        case ($urandom_range(0, 9))
          0, 1: q = $urandom_range(0, 1023);
          2: q = board.root % eff_size;
          default: q = $urandom_range(0, eff_size - 1);
        endcase
        send_query(q);
      end
      settle();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d queries and %0d neighbour items over %0d register writes",
             board.queries, board.entries, settings_used);
    $display("longest neighbour list %0d items, errors seen %0d",
             board.longest, board.errors);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (board.pending.size() != 0)
        $error("%0d neighbour items never arrived", board.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
